/* rtl/hmpp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash map probe unit package
// Sizes and derived widths used by the probe unit and to size its memories.
// ----------------------------------------------------------------------------
package hmpp_pkg;

  localparam int TABLE_BITS  = 10;
  localparam int KEY_WIDTH   = 64;
  localparam int VALUE_WIDTH = 64;
  localparam int HASH_WIDTH  = 32;

  localparam int KEY_PORT_W   = 64;
  localparam int VALUE_PORT_W = 64;
  localparam int COUNT_W      = 10;

  localparam int TABLE_SIZE = 1 << TABLE_BITS;
  localparam int CAPACITY   = (TABLE_SIZE * 2) / 3;
  localparam int KV_AW      = $clog2(CAPACITY);
  localparam int SLOT_W     = $clog2(CAPACITY + 1);
  localparam int KV_W       = KEY_WIDTH + VALUE_WIDTH;
  localparam int PERT_SHIFT = 5;

endpackage

/* rtl/hash_map_perturb_probe_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash map perturbation probe unit
// Open-addressing key-value map with a slot table over dense key/value stores.
// ----------------------------------------------------------------------------
// After reset the block clears every entry of the slot table and takes
// no beat until that is done. Items are then handled one at a time. Each
// probe step is a slot table read followed by a key/value store read and
// key compare; both are single-port memories with registered read data.
// An item is taken, then probes occupied slots one step each, and ends
// with a write back and the load of the result. A probe stops at an empty
// slot after its slot table read alone, or at a matching key after the
// store read of that slot. The next beat is taken while a result still
// waits.
module hash_map_perturb_probe_unit
  import hmpp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    op_i,
  input  logic [KEY_PORT_W-1:0]   key_i,
  input  logic [HASH_WIDTH-1:0]   key_hash_i,
  input  logic [VALUE_PORT_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    found_o,
  output logic [VALUE_PORT_W-1:0] value_out_o,
  output logic                    status_o,
  output logic [COUNT_W-1:0]      entry_count_o
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SLOT  = 5'b00100,
    ST_KV    = 5'b01000,
    ST_FIN   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [TABLE_BITS-1:0]  clr_q, clr_d;
  logic [TABLE_BITS-1:0]  idx_q, idx_d;
  logic [HASH_WIDTH-1:0]  pert_q, pert_d;
  logic                   op_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [SLOT_W-1:0]      slot_q, slot_d;
  logic                   hit_q, hit_d;
  logic [SLOT_W-1:0]      entries_q, entries_d;

  logic                    out_valid_q, out_valid_d;
  logic                    found_q, found_d;
  logic [VALUE_WIDTH-1:0]  value_out_q, value_out_d;
  logic                    status_q, status_d;

  logic                   slot_we, slot_re;
  logic [TABLE_BITS-1:0]  slot_addr;
  logic [SLOT_W-1:0]      slot_wdata, slot_rdata;
  logic                   kv_we, kv_re;
  logic [KV_AW-1:0]       kv_addr;
  logic [KV_W-1:0]        kv_wdata, kv_rdata;

  logic                   in_fire, fin_go, key_match;
  logic [HASH_WIDTH-1:0]  pert_next;
  logic [TABLE_BITS-1:0]  idx_next;

  assign in_fire   = in_valid_i && in_ready_o;
  assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign key_match = (kv_rdata[KV_W-1:VALUE_WIDTH] == key_q);
  assign pert_next = pert_q >> PERT_SHIFT;
  assign idx_next  = TABLE_BITS'({idx_q, 2'b00}) + idx_q + pert_next[TABLE_BITS-1:0]
                     + TABLE_BITS'(1);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    idx_d       = idx_q;
    pert_d      = pert_q;
    slot_d      = slot_q;
    hit_d       = hit_q;
    entries_d   = entries_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    value_out_d = value_out_q;
    status_d    = status_q;
    in_ready_o  = 1'b0;
    slot_we     = 1'b0;
    slot_re     = 1'b0;
    slot_addr   = idx_q;
    slot_wdata  = SLOT_W'(entries_q + SLOT_W'(1));
    kv_we       = 1'b0;
    kv_re       = 1'b0;
    kv_addr     = KV_AW'(slot_q - SLOT_W'(1));
    kv_wdata    = {key_q, value_q};

    case (state_q)
      ST_CLEAR: begin
        slot_we    = 1'b1;
        slot_addr  = clr_q;
        slot_wdata = '0;
        clr_d      = clr_q + TABLE_BITS'(1);
        if (clr_q == TABLE_BITS'(TABLE_SIZE - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        slot_addr  = key_hash_i[TABLE_BITS-1:0];
        if (in_valid_i) begin
          slot_re = 1'b1;
          idx_d   = key_hash_i[TABLE_BITS-1:0];
          pert_d  = key_hash_i;
          hit_d   = 1'b0;
          state_d = ST_SLOT;
        end
      end
      ST_SLOT: begin
        slot_d  = slot_rdata;
        kv_addr = KV_AW'(slot_rdata - SLOT_W'(1));
        if (slot_rdata == '0) begin
          state_d = ST_FIN;
        end else begin
          kv_re   = 1'b1;
          state_d = ST_KV;
        end
      end
      ST_KV: begin
        if (key_match) begin
          hit_d   = 1'b1;
          state_d = ST_FIN;
        end else begin
          pert_d    = pert_next;
          idx_d     = idx_next;
          slot_addr = idx_next;
          slot_re   = 1'b1;
          state_d   = ST_SLOT;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          out_valid_d = 1'b1;
          found_d     = hit_q;
          value_out_d = (!op_q && hit_q) ? kv_rdata[VALUE_WIDTH-1:0] : '0;
          status_d    = 1'b0;
          if (op_q) begin
            if (hit_q) begin
              kv_we = 1'b1;
            end else if (entries_q < SLOT_W'(CAPACITY)) begin
              kv_we     = 1'b1;
              kv_addr   = KV_AW'(entries_q);
              slot_we   = 1'b1;
              entries_d = SLOT_W'(entries_q + SLOT_W'(1));
            end else begin
              status_d = 1'b1;
            end
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      hit_q       <= 1'b0;
      entries_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hit_q       <= hit_d;
      entries_q   <= entries_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    pert_q      <= pert_d;
    slot_q      <= slot_d;
    found_q     <= found_d;
    value_out_q <= value_out_d;
    status_q    <= status_d;
    if (in_fire) begin
      op_q    <= op_i;
      key_q   <= key_i[KEY_WIDTH-1:0];
      value_q <= value_i[VALUE_WIDTH-1:0];
    end
  end

  hmpp_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_SIZE)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .re_i    (slot_re),
    .addr_i  (slot_addr),
    .wdata_i (slot_wdata),
    .rdata_o (slot_rdata)
  );

  hmpp_ram #(
    .WIDTH (KV_W),
    .DEPTH (CAPACITY)
  ) u_kv_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we),
    .re_i    (kv_re),
    .addr_i  (kv_addr),
    .wdata_i (kv_wdata),
    .rdata_o (kv_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign value_out_o   = VALUE_PORT_W'(value_out_q);
  assign status_o      = status_q;
  assign entry_count_o = COUNT_W'(entries_q);

  a_entries_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entries_q <= SLOT_W'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  a_entries_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entries_q != $past(entries_q)) |-> (entries_q == SLOT_W'($past(entries_q) + SLOT_W'(1))))
    else $error("Entry count changed by other than one.");

  a_status_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(status_o && found_o))
    else $error("Refused insert reported as found.");

  a_no_write_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SLOT) || (state_q == ST_KV)) |-> (!slot_we && !kv_we))
    else $error("Memory written during a probe.");

endmodule

/* rtl/hmpp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module hmpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
